### hdl/hab_pkg.sv
// Shared constants and helpers for the HSV adjust and blend pipeline.
// No dependencies; imported by hsv_adjust_blend.
`default_nettype none

package hab_pkg;

    localparam int CHANNEL_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 12;
    localparam int CFG_INDEX_BITS   = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_HUE_SHIFT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SAT_GAIN  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VAL_GAIN  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLEND     = 3'd3;

    // Drop fb fraction bits, round to nearest, ties away from zero.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                     input int fb);
        logic signed [63:0] half;
        half = 64'sd1 <<< (fb - 1);
        if (x >= 0) begin
            rnd_shift = (x + half) >>> fb;
        end else begin
            rnd_shift = -((-x + half) >>> fb);
        end
    endfunction

endpackage

`default_nettype wire

### hdl/hsv_adjust_blend.sv
// HSV hue/saturation/value adjust with blend: the whole pixel pipeline.
// Depends on hab_pkg for constants and the rounding helper.
//
// Usage:
//   s_* carries one RGBA pixel per beat, m_* returns the adjusted pixel.
//   cfg_we/cfg_index/cfg_wdata write hue_shift (0), saturation_gain (1),
//   value_gain (2) and blend_factor (3); write only while the pipe is empty.
//   Throughput is one pixel per clock unless the receiver stalls. A beat
//   crosses FRAC_BITS + 14 register stages on its way to m_tvalid, the first
//   loaded at the accepting edge: three front stages (min/max, delta and
//   difference, dividends), FRAC_BITS + 3 stages of the pipelined restoring
//   dividers for saturation and hue (one quotient bit per stage), seven
//   stages of multiplies and roundings for the HSV-to-RGB step and blend,
//   then the output register.
//   Bypass pixels (blend zero or neutral settings) follow the same path and
//   latency, so order is kept.
//   When the receiver stalls with a beat on m_*, the whole pipe holds and
//   s_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits and loads the neutral settings
//   (hue 0.5, gains 1.0, blend 1.0).
`default_nettype none

module hsv_adjust_blend #(
    parameter int CHANNEL_BITS = hab_pkg::CHANNEL_BITS_DEF,
    parameter int FRAC_BITS    = hab_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_we,
    input  wire logic [hab_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [FRAC_BITS+1:0]                   cfg_wdata,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // red_in, green_in, blue_in, alpha_in from bit 0 up, zero padded
    input  wire logic [((4*CHANNEL_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // red_out, green_out, blue_out, alpha_out from bit 0 up, zero padded
    output logic [((4*CHANNEL_BITS+7)/8)*8-1:0]         m_tdata
);
    import hab_pkg::*;

    localparam int C  = CHANNEL_BITS;
    localparam int F  = FRAC_BITS;
    localparam int DW = ((4*C+7)/8)*8;
    localparam int Q  = F + 3;          // quotient bits per divider
    localparam int NW = C + F + 3;      // dividend width
    localparam int TW = F + 5;          // shifted hue width
    localparam int PW = C + F + 7;      // signed v2 product width
    localparam int CW = C + 5;          // signed HSV-to-RGB channel width
    localparam int SW = C + F + 8;      // blend sum width
    localparam int L  = Q + 11;         // stage count
    localparam int ONE = 1 << F;

    localparam logic [F:0]    HALF_HS  = (F+1)'(ONE / 2);
    localparam logic [F+1:0]  ONE_G    = (F+2)'(ONE);
    localparam logic [F:0]    ONE_F    = (F+1)'(ONE);
    localparam logic [TW-1:0] TURN_T   = TW'(6 * ONE);
    localparam logic [TW-1:0] TURN2_T  = TW'(12 * ONE);
    localparam logic [TW-1:0] THREE_T  = TW'(3 * ONE);
    localparam logic [C-1:0]  CH_MAX   = {C{1'b1}};

    typedef enum logic [1:0] {SEL_RED, SEL_GREEN, SEL_BLUE} sel_t;

    typedef struct packed {
        logic         byp;
        logic [C-1:0] a;
        logic [C-1:0] b;
        logic [C-1:0] g;
        logic [C-1:0] r;
    } pix_t;

    // configuration
    logic [F:0]   hue_shift_reg;
    logic [F+1:0] sat_gain_reg;
    logic [F+1:0] val_gain_reg;
    logic [F:0]   blend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hue_shift_reg <= HALF_HS;
            sat_gain_reg  <= ONE_G;
            val_gain_reg  <= ONE_G;
            blend_reg     <= ONE_F;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_HUE_SHIFT: hue_shift_reg <= cfg_wdata[F:0];
                REG_SAT_GAIN:  sat_gain_reg  <= cfg_wdata;
                REG_VAL_GAIN:  val_gain_reg  <= cfg_wdata;
                REG_BLEND:     blend_reg     <= cfg_wdata[F:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic valid_reg [L];
    pix_t pix_reg [L];
    pix_t pix_next;

    assign en       = !valid_reg[L-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[L-1];

    // stage 0: capture, max/min
    logic [C-1:0] r_in, g_in, b_in;
    sel_t         msel0_next, msel0_reg;
    logic [C-1:0] cmax0_next, cmax0_reg, cmin0_next, cmin0_reg;

    assign r_in = s_tdata[C-1:0];
    assign g_in = s_tdata[2*C-1:C];
    assign b_in = s_tdata[3*C-1:2*C];

    always_comb begin
        pix_next.r   = r_in;
        pix_next.g   = g_in;
        pix_next.b   = b_in;
        pix_next.a   = s_tdata[4*C-1:3*C];
        pix_next.byp = (blend_reg == '0) ||
                       (hue_shift_reg == HALF_HS && sat_gain_reg == ONE_G &&
                        val_gain_reg == ONE_G);
        if (r_in >= g_in && r_in >= b_in) begin
            msel0_next = SEL_RED;
            cmax0_next = r_in;
        end else if (g_in >= b_in) begin
            msel0_next = SEL_GREEN;
            cmax0_next = g_in;
        end else begin
            msel0_next = SEL_BLUE;
            cmax0_next = b_in;
        end
        cmin0_next = r_in;
        if (g_in < cmin0_next) cmin0_next = g_in;
        if (b_in < cmin0_next) cmin0_next = b_in;
    end

    // stage 1: delta and channel difference
    logic [C-1:0]        delta1_next, delta1_reg, cmax1_reg;
    logic signed [C:0]   diff1_next, diff1_reg;
    sel_t                msel1_reg;

    always_comb begin
        delta1_next = cmax0_reg - cmin0_reg;
        unique case (msel0_reg)
            SEL_RED:   diff1_next = $signed({1'b0, pix_reg[0].g}) -
                                    $signed({1'b0, pix_reg[0].b});
            SEL_GREEN: diff1_next = $signed({1'b0, pix_reg[0].b}) -
                                    $signed({1'b0, pix_reg[0].r});
            default:   diff1_next = $signed({1'b0, pix_reg[0].r}) -
                                    $signed({1'b0, pix_reg[0].g});
        endcase
    end

    // stage 2: dividends and divisors
    logic [NW-1:0]       sdiv2_next, sdiv2_reg, hdiv2_next, hdiv2_reg;
    logic [C-1:0]        sdvs2_next, sdvs2_reg, hdvs2_next, hdvs2_reg, cmax2_reg;
    logic signed [C+3:0] base2, n0_2;
    logic [C+3:0]        six_d2;

    always_comb begin
        unique case (msel1_reg)
            SEL_RED:   base2 = '0;
            SEL_GREEN: base2 = $signed((C+4)'(delta1_reg) << 1);
            default:   base2 = $signed((C+4)'(delta1_reg) << 2);
        endcase
        six_d2 = ((C+4)'(delta1_reg) << 2) + ((C+4)'(delta1_reg) << 1);
        n0_2   = base2 + (C+4)'(diff1_reg);
        if (n0_2 < 0) n0_2 = n0_2 + $signed(six_d2);
        if (delta1_reg != '0) begin
            sdiv2_next = (NW'(delta1_reg) << F) + NW'(cmax1_reg >> 1);
            sdvs2_next = cmax1_reg;
            hdiv2_next = (NW'(n0_2[C+2:0]) << F) + NW'(delta1_reg >> 1);
            hdvs2_next = delta1_reg;
        end else begin
            // grey pixel: zero over one gives hue and saturation of zero
            sdiv2_next = '0;
            sdvs2_next = C'(1);
            hdiv2_next = '0;
            hdvs2_next = C'(1);
        end
    end

    // divider stages, one quotient bit each, MSB first
    logic [NW-1:0] srem_reg [Q];
    logic [NW-1:0] srem_next [Q];
    logic [NW-1:0] hrem_reg [Q];
    logic [NW-1:0] hrem_next [Q];
    logic [Q-1:0]  squo_reg [Q];
    logic [Q-1:0]  squo_next [Q];
    logic [Q-1:0]  hquo_reg [Q];
    logic [Q-1:0]  hquo_next [Q];
    logic [C-1:0]  sdvs_reg [Q];
    logic [C-1:0]  hdvs_reg [Q];
    logic [C-1:0]  dcmax_reg [Q];

    always_comb begin
        logic [NW-1:0] srin, hrin, strial, htrial;
        logic [Q-1:0]  sqin, hqin;
        logic [C-1:0]  sd, hd;
        for (int i = 0; i < Q; i++) begin
            if (i == 0) begin
                srin = sdiv2_reg; hrin = hdiv2_reg;
                sqin = '0;        hqin = '0;
                sd   = sdvs2_reg; hd   = hdvs2_reg;
            end else begin
                srin = srem_reg[i-1]; hrin = hrem_reg[i-1];
                sqin = squo_reg[i-1]; hqin = hquo_reg[i-1];
                sd   = sdvs_reg[i-1]; hd   = hdvs_reg[i-1];
            end
            strial = NW'(sd) << (Q - 1 - i);
            htrial = NW'(hd) << (Q - 1 - i);
            if (srin >= strial) begin
                srem_next[i] = srin - strial;
                squo_next[i] = sqin | (Q'(1) << (Q - 1 - i));
            end else begin
                srem_next[i] = srin;
                squo_next[i] = sqin;
            end
            if (hrin >= htrial) begin
                hrem_next[i] = hrin - htrial;
                hquo_next[i] = hqin | (Q'(1) << (Q - 1 - i));
            end else begin
                hrem_next[i] = hrin;
                hquo_next[i] = hqin;
            end
        end
    end

    // T1: shifted hue (plus one turn so it stays positive), gain products
    logic [TW-1:0]     tt_next, tt_reg;
    logic [2*F+4:0]    psat_next, psat_reg;
    logic [C+F+1:0]    pval_next, pval_reg;

    always_comb begin
        tt_next   = TW'(hquo_reg[Q-1]) + TW'(hue_shift_reg) * TW'(6) + THREE_T;
        psat_next = (2*F+5)'(squo_reg[Q-1]) * (2*F+5)'(sat_gain_reg);
        pval_next = (C+F+2)'(dcmax_reg[Q-1]) * (C+F+2)'(val_gain_reg);
    end

    // T2: wrap hue, round gains
    logic [TW-1:0]  t2a, t2b;
    logic [2:0]     sec2_next, sec2_reg;
    logic [F-1:0]   f2_next, f2_reg;
    logic [F+2:0]   s2_next, s2_reg;
    logic [C+1:0]   v2_next, v2_reg;

    always_comb begin
        t2a = (tt_reg >= TURN2_T) ? tt_reg - TURN2_T : tt_reg;
        t2b = (t2a >= TURN_T) ? t2a - TURN_T : t2a;
        sec2_next = t2b[F+2:F];
        f2_next   = t2b[F-1:0];
        s2_next   = (F+3)'(rnd_shift(64'(psat_reg), F));
        v2_next   = (C+2)'(rnd_shift(64'(pval_reg), F));
    end

    // T3: saturation times fraction
    logic [2*F+3:0]      psf_next, psf_reg, psnf_next, psnf_reg;
    logic signed [F+3:0] oms3_next, oms3_reg;
    logic [C+1:0]        v3_reg;
    logic [2:0]          sec3_reg;

    always_comb begin
        psf_next  = (2*F+4)'(s2_reg) * (2*F+4)'(f2_reg);
        psnf_next = (2*F+4)'(s2_reg) * (2*F+4)'(ONE_F - (F+1)'(f2_reg));
        oms3_next = $signed((F+4)'(ONE)) - $signed({1'b0, s2_reg});
    end

    // T4: round and complement
    logic signed [F+3:0] oma4_next, oma4_reg, omb4_next, omb4_reg, oms4_reg;
    logic [C+1:0]        v4_reg;
    logic [2:0]          sec4_reg;

    always_comb begin
        oma4_next = $signed((F+4)'(ONE)) -
                    $signed({1'b0, (F+3)'(rnd_shift(64'(psf_reg), F))});
        omb4_next = $signed((F+4)'(ONE)) -
                    $signed({1'b0, (F+3)'(rnd_shift(64'(psnf_reg), F))});
    end

    // T5: value times complements
    logic signed [PW-1:0] pp5_next, pp5_reg, pq5_next, pq5_reg, pu5_next, pu5_reg;
    logic [C+1:0]         v5_reg;
    logic [2:0]           sec5_reg;
    logic signed [PW-1:0] v4_s;

    always_comb begin
        v4_s     = PW'($signed({1'b0, v4_reg}));
        pp5_next = v4_s * PW'(oms4_reg);
        pq5_next = v4_s * PW'(oma4_reg);
        pu5_next = v4_s * PW'(omb4_reg);
    end

    // T6: round and pick sector
    logic signed [CW-1:0] p6, q6, u6, vv6;
    logic signed [CW-1:0] col6_next [3];
    logic signed [CW-1:0] col6_reg [3];

    always_comb begin
        p6  = CW'(rnd_shift(64'(pp5_reg), F));
        q6  = CW'(rnd_shift(64'(pq5_reg), F));
        u6  = CW'(rnd_shift(64'(pu5_reg), F));
        vv6 = $signed(CW'(v5_reg));
        unique case (sec5_reg)
            3'd0:    begin col6_next[0] = vv6; col6_next[1] = u6;  col6_next[2] = p6;  end
            3'd1:    begin col6_next[0] = q6;  col6_next[1] = vv6; col6_next[2] = p6;  end
            3'd2:    begin col6_next[0] = p6;  col6_next[1] = vv6; col6_next[2] = u6;  end
            3'd3:    begin col6_next[0] = p6;  col6_next[1] = q6;  col6_next[2] = vv6; end
            3'd4:    begin col6_next[0] = u6;  col6_next[1] = p6;  col6_next[2] = vv6; end
            default: begin col6_next[0] = vv6; col6_next[1] = p6;  col6_next[2] = q6;  end
        endcase
    end

    // T7: blend products
    logic [F:0]           fac7, ofac7;
    logic [C+F:0]         m0_next [3];
    logic [C+F:0]         m0_reg [3];
    logic signed [SW-1:0] m1_next [3];
    logic signed [SW-1:0] m1_reg [3];
    logic [C-1:0]         ch6 [3];

    assign ch6[0] = pix_reg[Q+8].r;
    assign ch6[1] = pix_reg[Q+8].g;
    assign ch6[2] = pix_reg[Q+8].b;

    always_comb begin
        fac7  = (blend_reg > ONE_F) ? ONE_F : blend_reg;
        ofac7 = ONE_F - fac7;
        for (int k = 0; k < 3; k++) begin
            m0_next[k] = (C+F+1)'(ofac7) * (C+F+1)'(ch6[k]);
            m1_next[k] = SW'($signed({1'b0, fac7})) * SW'(col6_reg[k]);
        end
    end

    // T8: sum, round, clamp (or pass bypass pixels through) into the output register
    logic [C-1:0]         out_next [3];
    logic [C-1:0]         out_reg [3];
    logic [C-1:0]         ch7 [3];
    logic signed [SW-1:0] sum8;
    logic signed [63:0]   rv8;

    assign ch7[0] = pix_reg[Q+9].r;
    assign ch7[1] = pix_reg[Q+9].g;
    assign ch7[2] = pix_reg[Q+9].b;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum8 = SW'($signed({1'b0, m0_reg[k]})) + m1_reg[k];
            rv8  = rnd_shift(64'(sum8), F);
            if (pix_reg[Q+9].byp) begin
                out_next[k] = ch7[k];
            end else if (rv8 < 0) begin
                out_next[k] = '0;
            end else if (rv8 > $signed(64'(CH_MAX))) begin
                out_next[k] = CH_MAX;
            end else begin
                out_next[k] = C'(rv8);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < L; i++) valid_reg[i] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= s_tvalid;
            for (int i = 1; i < L; i++) valid_reg[i] <= valid_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pix_reg[0] <= pix_next;
            for (int i = 1; i < L; i++) pix_reg[i] <= pix_reg[i-1];

            msel0_reg <= msel0_next;
            cmax0_reg <= cmax0_next;
            cmin0_reg <= cmin0_next;

            delta1_reg <= delta1_next;
            diff1_reg  <= diff1_next;
            msel1_reg  <= msel0_reg;
            cmax1_reg  <= cmax0_reg;

            sdiv2_reg <= sdiv2_next;
            sdvs2_reg <= sdvs2_next;
            hdiv2_reg <= hdiv2_next;
            hdvs2_reg <= hdvs2_next;
            cmax2_reg <= cmax1_reg;

            for (int i = 0; i < Q; i++) begin
                srem_reg[i] <= srem_next[i];
                squo_reg[i] <= squo_next[i];
                hrem_reg[i] <= hrem_next[i];
                hquo_reg[i] <= hquo_next[i];
            end
            sdvs_reg[0]  <= sdvs2_reg;
            hdvs_reg[0]  <= hdvs2_reg;
            dcmax_reg[0] <= cmax2_reg;
            for (int i = 1; i < Q; i++) begin
                sdvs_reg[i]  <= sdvs_reg[i-1];
                hdvs_reg[i]  <= hdvs_reg[i-1];
                dcmax_reg[i] <= dcmax_reg[i-1];
            end

            tt_reg   <= tt_next;
            psat_reg <= psat_next;
            pval_reg <= pval_next;

            sec2_reg <= sec2_next;
            f2_reg   <= f2_next;
            s2_reg   <= s2_next;
            v2_reg   <= v2_next;

            psf_reg  <= psf_next;
            psnf_reg <= psnf_next;
            oms3_reg <= oms3_next;
            v3_reg   <= v2_reg;
            sec3_reg <= sec2_reg;

            oma4_reg <= oma4_next;
            omb4_reg <= omb4_next;
            oms4_reg <= oms3_reg;
            v4_reg   <= v3_reg;
            sec4_reg <= sec3_reg;

            pp5_reg  <= pp5_next;
            pq5_reg  <= pq5_next;
            pu5_reg  <= pu5_next;
            v5_reg   <= v4_reg;
            sec5_reg <= sec4_reg;

            for (int k = 0; k < 3; k++) begin
                col6_reg[k] <= col6_next[k];
                m0_reg[k]   <= m0_next[k];
                m1_reg[k]   <= m1_next[k];
                out_reg[k]  <= out_next[k];
            end
        end
    end

    assign m_tdata = DW'({pix_reg[L-1].a, out_reg[2], out_reg[1], out_reg[0]});

endmodule

`default_nettype wire
